// ===== src/tfc_pkg.sv =====
// telemetry frame checker package: wrapper format codes, marker words and result type
// no dependencies
`default_nettype none

package tfc_pkg;

   localparam logic [1:0] FMT_LOS       = 2'd0;
   localparam logic [1:0] FMT_HIGH_RATE = 2'd1;
   localparam logic [1:0] FMT_LOW_RATE  = 2'd2;

   localparam int unsigned COUNT_W = 17;

   localparam logic [15:0] SYNC_WORD    = 16'hF00D;
   localparam logic [15:0] MARK_WORD    = 16'hD0CC;
   localparam logic [15:0] TYPE_MIN     = 16'hAE00;
   localparam logic [15:0] TYPE_MAX     = 16'hAE03;
   localparam logic [15:0] TRAIL_WORD_A = 16'hAEFF;
   localparam logic [15:0] TRAIL_WORD_B = 16'hC0FE;
   localparam logic [15:0] TRAIL_END_A  = 16'hD0CC;
   localparam logic [15:0] TRAIL_END_B  = 16'hF1EA;
   localparam logic [7:0]  LEAD_A       = 8'hC1;
   localparam logic [7:0]  LEAD_B       = 8'hC2;

   localparam logic [4:0] LOS_EXTRA       = 5'd26;
   localparam logic [4:0] HIGH_RATE_EXTRA = 5'd24;
   localparam logic [1:0] LOW_RATE_EXTRA  = 2'd3;

   // first member sits in the highest bits, so frame_good lands in bit 0
   typedef struct packed {
      logic [1:0]  pad;
      logic [3:0]  source;
      logic [7:0]  sequence_res;
      logic [15:0] crc_word;
      logic [31:0] buffer_number;
      logic        fill_flag;
      logic [15:0] declared_length;
      logic        frame_good;
   } tfc_result_type;

endpackage

`default_nettype wire

// ===== src/telemetry_frame_checker.sv =====
// telemetry_frame_checker: top level, byte stream in, one verdict transaction per packet out
// depends on tfc_pkg and tfc_frame_state
//
//  channel | direction | payload                                   | accepted when
//  req_    | in        | tdata: data_byte; tlast: last_byte        | req_tvalid && req_tready
//  rsp_    | out       | tdata: verdict and fields (see port)      | rsp_tvalid && rsp_tready
//  csr_    | in        | csr_data: frame_format                    | csr_valid && csr_ready
//
// one byte per cycle while req_tready is high; each byte updates the packet state in the cycle it is taken
// the final byte's verdict appears in the result register on the next cycle
// req_tready drops only while a result waits and rsp_tready is low
// synchronous reset clears the packet state and sets the format to high-rate
`default_nettype none

module telemetry_frame_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic        req_tlast,   // last_byte
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [79:0] rsp_tdata,   // frame_good, declared_length, fill_flag,
                                         // buffer_number, crc_word, sequence_res, source
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_data     // frame_format
);
   import tfc_pkg::*;

   logic           req_fire;
   logic           rsp_valid_ff, rsp_valid_in;
   tfc_result_type rsp_data_ff;
   tfc_result_type result;
   logic [1:0]     frame_format_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   tfc_frame_state u_state (
      .clock        (clock),
      .reset        (reset),
      .byte_take    (req_fire),
      .data_byte    (req_tdata),
      .last_byte    (req_tlast),
      .frame_format (frame_format_ff),
      .result       (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (req_fire && req_tlast) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         frame_format_ff <= FMT_HIGH_RATE;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) frame_format_ff <= csr_data;
      end
      if (req_fire && req_tlast) rsp_data_ff <= result;
   end

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire && req_tlast))
      else $error("result appeared without a final byte");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> rsp_valid_ff)
      else $error("final byte gave no result");

   a_reset_format: assert property (@(posedge clock)
      reset |=> frame_format_ff == FMT_HIGH_RATE)
      else $error("format not high-rate after reset");

endmodule

`default_nettype wire

// ===== src/tfc_frame_state.sv =====
// tfc_frame_state: per-packet byte counter, header checks, field capture and final verdict
// depends on tfc_pkg
`default_nettype none

module tfc_frame_state (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    byte_take,
   input  wire logic [7:0]              data_byte,
   input  wire logic                    last_byte,
   input  wire logic [1:0]              frame_format,
   output tfc_pkg::tfc_result_type      result
);
   import tfc_pkg::*;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic               count_overflow_ff, count_overflow_in;
   logic               header_ok_ff, header_ok_in;
   logic [15:0]        length_field_ff, length_field_in;
   logic               fill_bit_ff, fill_bit_in;
   logic [31:0]        buffer_field_ff, buffer_field_in;
   logic [63:0]        tail_window_ff, tail_window_in;
   logic [7:0]         lead_byte_ff, lead_byte_in;
   logic [7:0]         sequence_byte_ff, sequence_byte_in;

   logic [COUNT_W-1:0] pos;
   logic [15:0]        word;
   logic               los;
   logic [COUNT_W-1:0] buf0, len0, typ, buf_off;
   logic [15:0]        trail_a, trail_b, trail_end, crc;
   logic [COUNT_W:0]   total, expect_len;
   logic               good;

   always_comb begin
      pos               = byte_count_ff;
      word              = {data_byte, tail_window_ff[7:0]};
      los               = (frame_format == FMT_LOS);
      buf0              = los ? COUNT_W'(12) : COUNT_W'(6);
      len0              = los ? COUNT_W'(16) : COUNT_W'(14);
      typ               = los ? COUNT_W'(11) : COUNT_W'(5);
      buf_off           = pos - buf0;
      byte_count_in     = byte_count_ff;
      count_overflow_in = count_overflow_ff;
      header_ok_in      = header_ok_ff;
      length_field_in   = length_field_ff;
      fill_bit_in       = fill_bit_ff;
      buffer_field_in   = buffer_field_ff;
      lead_byte_in      = lead_byte_ff;
      sequence_byte_in  = sequence_byte_ff;

      if (!count_overflow_ff) begin
         if (frame_format == FMT_LOS || frame_format == FMT_HIGH_RATE) begin
            if (pos == COUNT_W'(1) && word != SYNC_WORD) header_ok_in = 1'b0;
            if (los) begin
               if (pos == COUNT_W'(7) && word != SYNC_WORD) header_ok_in = 1'b0;
               if (pos == COUNT_W'(9) && word != MARK_WORD) header_ok_in = 1'b0;
            end else begin
               if (pos == COUNT_W'(3) && word != MARK_WORD) header_ok_in = 1'b0;
            end
            if (pos == typ - COUNT_W'(1)) fill_bit_in = data_byte[1];
            if (pos == typ && (word < TYPE_MIN || word > TYPE_MAX)) header_ok_in = 1'b0;
            if (pos >= buf0 && buf_off < COUNT_W'(4))
               buffer_field_in = buffer_field_ff
                  | ({24'd0, data_byte} << {buf_off[1:0], 3'b000});
            if (pos == len0) length_field_in = {8'd0, data_byte};
            if (pos == len0 + COUNT_W'(1))
               length_field_in = length_field_ff | {data_byte, 8'd0};
         end else if (frame_format == FMT_LOW_RATE) begin
            if (pos == COUNT_W'(0)) begin
               lead_byte_in = data_byte;
               if (data_byte != LEAD_A && data_byte != LEAD_B) header_ok_in = 1'b0;
            end
            if (pos == COUNT_W'(1)) sequence_byte_in = data_byte;
            if (pos == COUNT_W'(2)) length_field_in = {8'd0, data_byte};
         end
      end
      tail_window_in = {tail_window_ff[55:0], data_byte};

      if (!last_byte) begin
         if (byte_count_ff == COUNT_MAX) count_overflow_in = 1'b1;
         else byte_count_in = byte_count_ff + COUNT_W'(1);
      end

      // verdict from the updated packet state
      trail_a   = {tail_window_in[39:32], tail_window_in[47:40]};
      trail_b   = {tail_window_in[23:16], tail_window_in[31:24]};
      trail_end = {tail_window_in[7:0],   tail_window_in[15:8]};
      crc       = {tail_window_in[55:48], tail_window_in[63:56]};
      total     = {1'b0, pos} + (COUNT_W+1)'(1);
      result    = '0;
      unique case (frame_format)
         FMT_LOS, FMT_HIGH_RATE: begin
            expect_len = (COUNT_W+1)'(length_field_in)
                       + (los ? (COUNT_W+1)'(LOS_EXTRA) : (COUNT_W+1)'(HIGH_RATE_EXTRA));
            good = header_ok_in && !count_overflow_ff
                && trail_a == TRAIL_WORD_A && trail_b == TRAIL_WORD_B
                && (trail_end == TRAIL_END_A || trail_end == TRAIL_END_B)
                && total == expect_len;
            result.frame_good      = good;
            result.declared_length = length_field_in;
            result.fill_flag       = fill_bit_in;
            result.buffer_number   = buffer_field_in;
            result.crc_word        = crc;
         end
         FMT_LOW_RATE: begin
            expect_len = (COUNT_W+1)'(length_field_in)
                       + (COUNT_W+1)'(LOW_RATE_EXTRA);
            good = header_ok_in && !count_overflow_ff && total == expect_len;
            result.frame_good      = good;
            result.declared_length = {8'd0, length_field_in[7:0]};
            result.sequence_res    = sequence_byte_in;
            result.source          = lead_byte_in[3:0];
         end
         default: begin
            expect_len = '0;
            good       = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || (byte_take && last_byte)) begin
         byte_count_ff     <= '0;
         count_overflow_ff <= 1'b0;
         header_ok_ff      <= 1'b1;
         length_field_ff   <= '0;
         fill_bit_ff       <= 1'b0;
         buffer_field_ff   <= '0;
         tail_window_ff    <= '0;
         lead_byte_ff      <= '0;
         sequence_byte_ff  <= '0;
      end else if (byte_take) begin
         byte_count_ff     <= byte_count_in;
         count_overflow_ff <= count_overflow_in;
         header_ok_ff      <= header_ok_in;
         length_field_ff   <= length_field_in;
         fill_bit_ff       <= fill_bit_in;
         buffer_field_ff   <= buffer_field_in;
         tail_window_ff    <= tail_window_in;
         lead_byte_ff      <= lead_byte_in;
         sequence_byte_ff  <= sequence_byte_in;
      end
   end

endmodule

`default_nettype wire
